// ----- rtl/barometer_trim_compensation_unit_assert.svh -----
// Assertion macros shared by the RTL files.
`ifndef BAROMETER_TRIM_COMPENSATION_UNIT_ASSERT_SVH
`define BAROMETER_TRIM_COMPENSATION_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
`define BTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define BTC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define BTC_ASSERT(lbl, prop, msg)
`define BTC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- rtl/btc_pkg.sv -----
`default_nettype none
package btc_pkg;

  localparam int unsigned RAW_W        = 20;
  localparam int unsigned TEMP_W       = 16;
  localparam int unsigned PRESS_W      = 25;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 64;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam logic [63:0] T_FINE_OFFSET = 64'd128000;
  localparam logic [63:0] PRESS_ONE     = 64'd1048576;
  localparam logic [63:0] P1_BIAS       = 64'h0000_8000_0000_0000;
  localparam logic [63:0] NUM_SCALE     = 64'd3125;
  localparam logic [PRESS_W-1:0] PRESS_MAX = {PRESS_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEMP       = 2'd0,
    CFG_PRESS_LO   = 2'd1,
    CFG_PRESS_HI   = 2'd2,
    CFG_PRESS_NINE = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] t3;
    logic [15:0] t2;
    logic [15:0] t1;
  } temp_coef_t;

  typedef struct packed {
    logic [15:0] p9;
    logic [15:0] p8;
    logic [15:0] p7;
    logic [15:0] p6;
    logic [15:0] p5;
    logic [15:0] p4;
    logic [15:0] p3;
    logic [15:0] p2;
    logic [15:0] p1;
  } press_coef_t;

  typedef struct packed {
    logic [TEMP_W-1:0] temp_centi;
    logic [31:0]       t_fine;
    logic [RAW_W-1:0]  raw_press;
  } item_t;

  function automatic logic [63:0] sx64(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  function automatic logic [63:0] asr64(input logic [63:0] x, input int unsigned n);
    return $unsigned($signed(x) >>> n);
  endfunction

endpackage
`default_nettype wire

// ----- rtl/btc_in_if.sv -----
`default_nettype none
interface btc_in_if;
  logic                         valid;
  logic                         ready;
  logic [btc_pkg::RAW_W-1:0]    raw_temp;
  logic [btc_pkg::RAW_W-1:0]    raw_press;

  modport source (output valid, output raw_temp, output raw_press, input ready);
  modport sink (input valid, input raw_temp, input raw_press, output ready);
endinterface
`default_nettype wire

// ----- rtl/btc_out_if.sv -----
`default_nettype none
interface btc_out_if;
  logic                          valid;
  logic                          ready;
  logic [btc_pkg::TEMP_W-1:0]    temp_centi;
  logic [btc_pkg::PRESS_W-1:0]   press_q8;
  logic                          press_valid;

  modport source (output valid, output temp_centi, output press_q8, output press_valid,
                  input ready);
  modport sink (input valid, input temp_centi, input press_q8, input press_valid,
                output ready);
endinterface
`default_nettype wire

// ----- rtl/btc_cfg_if.sv -----
`default_nettype none
interface btc_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [btc_pkg::CFG_IDX_W-1:0]    index;
  logic [btc_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/barometer_trim_compensation_unit.sv -----
// Barometric trim compensation unit.
// Channels: in_i takes one raw temperature and raw pressure pair per transfer;
// out_o gives temperature in 0.01 degC, pressure in Pa as unsigned Q17.8 and
// press_valid, which is low (pressure 0) when the pressure divisor is zero.
// cfg_i writes the four coefficient registers (index 0 temperature, 1 and 2
// packed pressure coefficients, 3 the ninth one); it is always ready. The
// user must write it only while the unit is idle; the unit does not enforce this.
// Path: temperature pipeline, then the queue, then the pressure engine,
// which skips the divider and the last products when the divisor is zero.
// The engine takes one item at a time from the queue; its single 32x32
// multiplier is stepped over ten 64-bit products and it runs the 64-step
// shift-subtract divider. The front keeps taking samples into the queue
// while the engine works, so short bursts are absorbed.
// Reset clears all coefficients to zero and empties pipeline and queue.
// When the receiver stalls the result holds in the output register, the
// engine finishes the next item and waits; queue and front fill, then
// in_i.ready drops.
`default_nettype none
module barometer_trim_compensation_unit #(
  parameter int unsigned QUEUE_DEPTH = btc_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  btc_in_if.sink     in_i,
  btc_out_if.source  out_o,
  btc_cfg_if.sink    cfg_i
);

  logic [47:0] temp_cfg_q;
  logic [63:0] plo_cfg_q, phi_cfg_q;
  logic [15:0] p9_cfg_q;

  btc_pkg::temp_coef_t  tcoef;
  btc_pkg::press_coef_t pcoef;

  logic           push, push_ready, pop, pop_valid;
  btc_pkg::item_t fr_item, q_item;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_cfg_q <= '0;
      plo_cfg_q  <= '0;
      phi_cfg_q  <= '0;
      p9_cfg_q   <= '0;
    end else if (cfg_i.valid) begin
      case (btc_pkg::cfg_idx_e'(cfg_i.index))
        btc_pkg::CFG_TEMP:       temp_cfg_q <= cfg_i.data[47:0];
        btc_pkg::CFG_PRESS_LO:   plo_cfg_q  <= cfg_i.data;
        btc_pkg::CFG_PRESS_HI:   phi_cfg_q  <= cfg_i.data;
        btc_pkg::CFG_PRESS_NINE: p9_cfg_q   <= cfg_i.data[15:0];
        default: begin
        end
      endcase
    end
  end

  assign tcoef = btc_pkg::temp_coef_t'(temp_cfg_q);
  assign pcoef = btc_pkg::press_coef_t'({p9_cfg_q, phi_cfg_q, plo_cfg_q});

  btc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .coef_i       (tcoef),
    .push_o       (push),
    .push_ready_i (push_ready),
    .item_o       (fr_item)
  );

  btc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .data_i       (fr_item),
    .pop_i        (pop),
    .pop_valid_o  (pop_valid),
    .data_o       (q_item)
  );

  btc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_o       (pop),
    .item_i      (q_item),
    .coef_i      (pcoef),
    .out_o       (out_o)
  );

endmodule
`default_nettype wire

// ----- rtl/btc_front.sv -----
`default_nettype none
module btc_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  btc_in_if.sink                   in_i,
  input  wire btc_pkg::temp_coef_t coef_i,
  output logic                     push_o,
  input  wire logic                push_ready_i,
  output btc_pkg::item_t           item_o
);

  logic rdy;
  logic vld1_q, vld2_q, vld3_q, vld4_q;

  logic signed [17:0] a_d, a_q;
  logic signed [16:0] b_d, b_q;
  logic [btc_pkg::RAW_W-1:0] pr1_q, pr2_q, pr3_q, pr4_q;

  logic signed [33:0] pa, pb;
  logic signed [31:0] v1_d, v1_q, bb_d, bb_q;

  logic signed [47:0] pc;
  logic signed [31:0] tf_d, tf_q, tf4_q;

  logic signed [31:0] t5, tc;
  logic [btc_pkg::TEMP_W-1:0] temp_d, temp_q;

  assign rdy        = !vld4_q || push_ready_i;
  assign in_i.ready = rdy;

  assign a_d = $signed({1'b0, in_i.raw_temp[19:3]}) - $signed({1'b0, coef_i.t1, 1'b0});
  assign b_d = $signed({1'b0, in_i.raw_temp[19:4]}) - $signed({1'b0, coef_i.t1});

  assign pa   = a_q * $signed(coef_i.t2);
  assign pb   = b_q * b_q;
  assign v1_d = $signed(pa[31:0]) >>> 11;
  assign bb_d = $signed(pb[31:0]) >>> 12;

  assign pc   = bb_q * $signed(coef_i.t3);
  assign tf_d = v1_q + ($signed(pc[31:0]) >>> 14);

  assign t5 = (tf_q <<< 2) + tf_q + 32'sd128;
  assign tc = t5 >>> 8;

  always_comb begin
    if (tc > 32'sd32767) begin
      temp_d = 16'h7FFF;
    end else if (tc < -32'sd32768) begin
      temp_d = 16'h8000;
    end else begin
      temp_d = tc[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
      vld4_q <= 1'b0;
    end else if (rdy) begin
      vld1_q <= in_i.valid;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
      vld4_q <= vld3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy) begin
      a_q    <= a_d;
      b_q    <= b_d;
      pr1_q  <= in_i.raw_press;
      v1_q   <= v1_d;
      bb_q   <= bb_d;
      pr2_q  <= pr1_q;
      tf_q   <= tf_d;
      pr3_q  <= pr2_q;
      temp_q <= temp_d;
      tf4_q  <= tf_q;
      pr4_q  <= pr3_q;
    end
  end

  assign push_o = vld4_q;
  assign item_o = {temp_q, tf4_q, pr4_q};

endmodule
`default_nettype wire

// ----- rtl/btc_fifo.sv -----
`default_nettype none
`include "barometer_trim_compensation_unit_assert.svh"
module btc_fifo #(
  parameter int unsigned DEPTH = btc_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  output logic                push_ready_o,
  input  wire btc_pkg::item_t data_i,
  input  wire logic           pop_i,
  output logic                pop_valid_o,
  output btc_pkg::item_t      data_o
);

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  btc_pkg::item_t     mem_q [DEPTH];
  logic [IDX_W-1:0]   wr_q, rd_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               do_push, do_pop;

  assign push_ready_o = (cnt_q != CNT_FULL);
  assign pop_valid_o  = (cnt_q != '0);
  assign data_o       = mem_q[rd_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == IDX_LAST) ? '0 : wr_q + IDX_W'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == IDX_LAST) ? '0 : rd_q + IDX_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  `BTC_ASSERT(a_fifo_cnt_range, cnt_q <= CNT_FULL, "queue fill count above depth")
  `BTC_ASSERT(a_fifo_cnt_up, do_push && !do_pop |=> cnt_q == $past(cnt_q) + CNT_W'(1), "no advance")
  `BTC_ASSERT(a_fifo_cnt_dn, do_pop && !do_push |=> cnt_q == $past(cnt_q) - CNT_W'(1), "no drop")

endmodule
`default_nettype wire

// ----- rtl/btc_back.sv -----
`default_nettype none
`include "barometer_trim_compensation_unit_assert.svh"
module btc_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 pop_valid_i,
  output logic                      pop_o,
  input  wire btc_pkg::item_t       item_i,
  input  wire btc_pkg::press_coef_t coef_i,
  btc_out_if.source                 out_o
);

  localparam int unsigned DIV_STEPS = 64;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);
  localparam logic [1:0] MS_LAST = 2'd2;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL  = 6'b000010,
    ST_PREP = 6'b000100,
    ST_DIV  = 6'b001000,
    ST_SIGN = 6'b010000,
    ST_FIN  = 6'b100000
  } state_e;

  typedef enum logic [3:0] {
    OP_SQ  = 4'd0,
    OP_W2A = 4'd1,
    OP_W2B = 4'd2,
    OP_V1A = 4'd3,
    OP_V1B = 4'd4,
    OP_DEN = 4'd5,
    OP_NUM = 4'd6,
    OP_X1A = 4'd7,
    OP_X1B = 4'd8,
    OP_X2  = 4'd9
  } op_e;

  state_e state_d, state_q;
  op_e    op_d, op_q;
  logic [1:0]  ms_d, ms_q;
  logic [63:0] acc_d, acc_q, opa_d, opa_q, opb_d, opb_q;
  logic [63:0] w1_d, w1_q, sq_d, sq_q, w2_d, w2_q, t_d, t_q;
  logic [63:0] den_d, den_q, dvd_d, dvd_q, rem_d, rem_q;
  logic [63:0] q_d, q_q, x1_d, x1_q, s_d, s_q;
  logic        neg_d, neg_q, inval_d, inval_q;
  logic [CNT_W-1:0] cnt_d, cnt_q;
  logic [btc_pkg::TEMP_W-1:0]  temp_d, temp_q;
  logic [btc_pkg::RAW_W-1:0]   adcp_d, adcp_q;

  logic [31:0] ma, mb;
  logic [63:0] prod, msum, pp, qs, v1b, den_new;
  logic [63:0] p2x, p3x, p4x, p5x, p6x, p7x, p8x, p9x;
  logic [64:0] shl, diff;
  logic [63:0] sf;
  logic [btc_pkg::PRESS_W-1:0] press_fin;

  logic load;
  logic ov_q;
  logic [btc_pkg::TEMP_W-1:0]  temp_out_q;
  logic [btc_pkg::PRESS_W-1:0] press_out_q;
  logic                        pv_out_q;

  assign p2x = btc_pkg::sx64(coef_i.p2);
  assign p3x = btc_pkg::sx64(coef_i.p3);
  assign p4x = btc_pkg::sx64(coef_i.p4);
  assign p5x = btc_pkg::sx64(coef_i.p5);
  assign p6x = btc_pkg::sx64(coef_i.p6);
  assign p7x = btc_pkg::sx64(coef_i.p7);
  assign p8x = btc_pkg::sx64(coef_i.p8);
  assign p9x = btc_pkg::sx64(coef_i.p9);

  assign ma   = (ms_q == MS_LAST) ? opa_q[63:32] : opa_q[31:0];
  assign mb   = (ms_q == 2'd1) ? opb_q[63:32] : opb_q[31:0];
  assign prod = ma * mb;
  assign msum = (ms_q == 2'd0) ? prod : acc_q + {prod[31:0], 32'b0};

  assign pp      = btc_pkg::PRESS_ONE - {44'b0, adcp_q};
  assign v1b     = t_q + {msum[51:0], 12'b0};
  assign den_new = btc_pkg::asr64(msum, 33);
  assign qs      = neg_q ? (64'd0 - dvd_q) : dvd_q;

  assign shl  = {rem_q, dvd_q[63]};
  assign diff = shl - {1'b0, den_q};

  assign sf = btc_pkg::asr64(s_q, 8) + {p7x[59:0], 4'b0};

  always_comb begin
    if (sf[63]) begin
      press_fin = '0;
    end else if (sf[62:btc_pkg::PRESS_W] != '0) begin
      press_fin = btc_pkg::PRESS_MAX;
    end else begin
      press_fin = sf[btc_pkg::PRESS_W-1:0];
    end
  end

  assign pop_o = (state_q == ST_IDLE);
  assign load  = (state_q == ST_FIN) && (!ov_q || out_o.ready);

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    ms_d    = ms_q;
    acc_d   = acc_q;
    opa_d   = opa_q;
    opb_d   = opb_q;
    w1_d    = w1_q;
    sq_d    = sq_q;
    w2_d    = w2_q;
    t_d     = t_q;
    den_d   = den_q;
    dvd_d   = dvd_q;
    rem_d   = rem_q;
    q_d     = q_q;
    x1_d    = x1_q;
    s_d     = s_q;
    neg_d   = neg_q;
    inval_d = inval_q;
    cnt_d   = cnt_q;
    temp_d  = temp_q;
    adcp_d  = adcp_q;
    case (state_q)
      ST_IDLE: begin
        if (pop_valid_i) begin
          temp_d  = item_i.temp_centi;
          adcp_d  = item_i.raw_press;
          w1_d    = {{32{item_i.t_fine[31]}}, item_i.t_fine} - btc_pkg::T_FINE_OFFSET;
          opa_d   = w1_d;
          opb_d   = w1_d;
          op_d    = OP_SQ;
          ms_d    = '0;
          inval_d = 1'b0;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        if (ms_q != MS_LAST) begin
          acc_d = msum;
          ms_d  = ms_q + 2'd1;
        end else begin
          ms_d = '0;
          case (op_q)
            OP_SQ: begin
              sq_d  = msum;
              opa_d = msum;
              opb_d = p6x;
              op_d  = OP_W2A;
            end
            OP_W2A: begin
              w2_d  = msum;
              opa_d = w1_q;
              opb_d = p5x;
              op_d  = OP_W2B;
            end
            OP_W2B: begin
              w2_d  = w2_q + {msum[46:0], 17'b0} + {p4x[28:0], 35'b0};
              opa_d = sq_q;
              opb_d = p3x;
              op_d  = OP_V1A;
            end
            OP_V1A: begin
              t_d   = btc_pkg::asr64(msum, 8);
              opa_d = w1_q;
              opb_d = p2x;
              op_d  = OP_V1B;
            end
            OP_V1B: begin
              opa_d = btc_pkg::P1_BIAS + v1b;
              opb_d = {48'b0, coef_i.p1};
              op_d  = OP_DEN;
            end
            OP_DEN: begin
              den_d = den_new;
              if (den_new == '0) begin
                inval_d = 1'b1;
                state_d = ST_FIN;
              end else begin
                opa_d = {pp[32:0], 31'b0} - w2_q;
                opb_d = btc_pkg::NUM_SCALE;
                op_d  = OP_NUM;
              end
            end
            OP_NUM: begin
              dvd_d   = msum;
              neg_d   = msum[63] ^ den_q[63];
              state_d = ST_PREP;
            end
            OP_X1A: begin
              opa_d = msum;
              opb_d = btc_pkg::asr64(q_q, 13);
              op_d  = OP_X1B;
            end
            OP_X1B: begin
              x1_d  = btc_pkg::asr64(msum, 25);
              opa_d = p8x;
              opb_d = q_q;
              op_d  = OP_X2;
            end
            OP_X2: begin
              s_d     = q_q + x1_q + btc_pkg::asr64(msum, 19);
              state_d = ST_FIN;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_PREP: begin
        dvd_d   = dvd_q[63] ? (64'd0 - dvd_q) : dvd_q;
        den_d   = den_q[63] ? (64'd0 - den_q) : den_q;
        rem_d   = '0;
        cnt_d   = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (!diff[64]) begin
          rem_d = diff[63:0];
          dvd_d = {dvd_q[62:0], 1'b1};
        end else begin
          rem_d = shl[63:0];
          dvd_d = {dvd_q[62:0], 1'b0};
        end
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_LAST) begin
          state_d = ST_SIGN;
        end
      end
      ST_SIGN: begin
        q_d     = qs;
        opa_d   = p9x;
        opb_d   = btc_pkg::asr64(qs, 13);
        op_d    = OP_X1A;
        ms_d    = '0;
        state_d = ST_MUL;
      end
      ST_FIN: begin
        if (load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_SQ;
      ms_q    <= '0;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      ms_q    <= ms_d;
      cnt_q   <= cnt_d;
      if (load) begin
        ov_q <= 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    opa_q   <= opa_d;
    opb_q   <= opb_d;
    w1_q    <= w1_d;
    sq_q    <= sq_d;
    w2_q    <= w2_d;
    t_q     <= t_d;
    den_q   <= den_d;
    dvd_q   <= dvd_d;
    rem_q   <= rem_d;
    q_q     <= q_d;
    x1_q    <= x1_d;
    s_q     <= s_d;
    neg_q   <= neg_d;
    inval_q <= inval_d;
    temp_q  <= temp_d;
    adcp_q  <= adcp_d;
    if (load) begin
      temp_out_q  <= temp_q;
      press_out_q <= inval_q ? '0 : press_fin;
      pv_out_q    <= !inval_q;
    end
  end

  assign out_o.valid       = ov_q;
  assign out_o.temp_centi  = temp_out_q;
  assign out_o.press_q8    = press_out_q;
  assign out_o.press_valid = pv_out_q;

  `BTC_ASSERT(a_fin_hold, (state_q == ST_FIN) && !load |=> (state_q == ST_FIN), "result dropped")
  `BTC_ASSERT(a_prep_div, (state_q == ST_PREP) |=> (state_q == ST_DIV), "divider not started")
  `BTC_ASSERT(a_invalid_zero, ov_q && !pv_out_q |-> press_out_q == '0, "invalid pressure not zero")

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;

  typedef struct packed {
    logic [btc_pkg::RAW_W-1:0] raw_temp;
    logic [btc_pkg::RAW_W-1:0] raw_press;
  } sample_t;

  typedef struct packed {
    logic signed [btc_pkg::TEMP_W-1:0] temp_centi;
    logic [btc_pkg::PRESS_W-1:0]       press_q8;
    logic                              press_valid;
  } reading_t;

  logic clk_i;
  logic rst_ni;

  btc_in_if  in_if ();
  btc_out_if out_if ();
  btc_cfg_if cfg_if ();

  barometer_trim_compensation_unit u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if.sink),
    .out_o (out_if.source),
    .cfg_i (cfg_if.sink)
  );

  logic [47:0] temp_coeffs;
  logic [63:0] press_lo;
  logic [63:0] press_hi;
  logic [15:0] press_nine;

  sample_t  pending_samples[$];
  reading_t expected_readings[$];
  int       n_errors;
  int       n_checked;
  int       n_invalid;
  int       n_sat;
  bit       calm;
  bit       stim_done;
  int       send_gap;
  int       recv_stall;
  int       quiet_cycles;
  bit       timed_out;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int N_RANDOM       = 2000;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [63:0] sext16(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  function automatic reading_t compensate(input sample_t s);
    reading_t r;
    logic signed [31:0] t1, t2, t3, a, b, v1, v2, t_fine, tc;
    logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic signed [63:0] w1, w2, p, ph, x1, x2, num;
    t1 = {16'd0, temp_coeffs[15:0]};
    t2 = {{16{temp_coeffs[31]}}, temp_coeffs[31:16]};
    t3 = {{16{temp_coeffs[47]}}, temp_coeffs[47:32]};
    p1 = {48'd0, press_lo[15:0]};
    p2 = sext16(press_lo[31:16]);
    p3 = sext16(press_lo[47:32]);
    p4 = sext16(press_lo[63:48]);
    p5 = sext16(press_hi[15:0]);
    p6 = sext16(press_hi[31:16]);
    p7 = sext16(press_hi[47:32]);
    p8 = sext16(press_hi[63:48]);
    p9 = sext16(press_nine);

    a = $signed({15'd0, s.raw_temp[19:3]}) - (t1 <<< 1);
    v1 = (a * t2) >>> 11;
    b = $signed({16'd0, s.raw_temp[19:4]}) - t1;
    v2 = (((b * b) >>> 12) * t3) >>> 14;
    t_fine = v1 + v2;
    tc = (t_fine * 32'sd5 + 32'sd128) >>> 8;
    if (tc < -32768) r.temp_centi = 16'h8000;
    else if (tc > 32767) r.temp_centi = 16'h7fff;
    else r.temp_centi = tc[15:0];

    w1 = 64'(t_fine) - 64'sd128000;
    w2 = w1 * w1 * p6;
    w2 = w2 + ((w1 * p5) <<< 17);
    w2 = w2 + (p4 <<< 35);
    w1 = ((w1 * w1 * p3) >>> 8) + ((w1 * p2) <<< 12);
    w1 = (((64'sd1 <<< 47) + w1) * p1) >>> 33;

    r.press_q8 = '0;
    r.press_valid = 1'b0;
    if (w1 != 0) begin
      p = 64'sd1048576 - $signed({44'd0, s.raw_press});
      num = ((p <<< 31) - w2) * 64'sd3125;
      p = num / w1;
      ph = p >>> 13;
      x1 = (p9 * ph * ph) >>> 25;
      x2 = (p8 * p) >>> 19;
      p = ((p + x1 + x2) >>> 8) + (p7 <<< 4);
      if (p < 0) r.press_q8 = '0;
      else if (p > 64'sd33554431) r.press_q8 = btc_pkg::PRESS_MAX;
      else r.press_q8 = p[btc_pkg::PRESS_W-1:0];
      r.press_valid = 1'b1;
    end
    return r;
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    n_errors++;
  endtask

  task automatic write_reg(input btc_pkg::cfg_idx_e idx, input logic [63:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
    case (idx)
      btc_pkg::CFG_TEMP:     temp_coeffs = value[47:0];
      btc_pkg::CFG_PRESS_LO: press_lo = value;
      btc_pkg::CFG_PRESS_HI: press_hi = value;
      default:               press_nine = value[15:0];
    endcase
  endtask

  task automatic drain();
    while (pending_samples.size() != 0 || expected_readings.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  task automatic push(input logic [19:0] t, input logic [19:0] pr);
    sample_t s;
    s.raw_temp = t;
    s.raw_press = pr;
    pending_samples.push_back(s);
  endtask

  // typical trim set for a real part
  task automatic load_nominal();
    write_reg(btc_pkg::CFG_TEMP, {16'hfc18, 16'h6689, 16'h6e93});
    write_reg(btc_pkg::CFG_PRESS_LO, {16'h0b27, 16'hd0d0, 16'hd5d4, 16'h8fb6});
    write_reg(btc_pkg::CFG_PRESS_HI, {16'hc6c6, 16'h3ce3, 16'hfff9, 16'h008c});
    write_reg(btc_pkg::CFG_PRESS_NINE, 64'h1770);
  endtask

  task automatic random_coeffs();
    write_reg(btc_pkg::CFG_TEMP, {$urandom, $urandom});
    write_reg(btc_pkg::CFG_PRESS_LO, {$urandom, $urandom});
    write_reg(btc_pkg::CFG_PRESS_HI, {$urandom, $urandom});
    write_reg(btc_pkg::CFG_PRESS_NINE, {$urandom, $urandom});
  endtask

  task automatic random_block(input int n, input bit nominal_range);
    for (int i = 0; i < n; i++) begin
      if (nominal_range && $urandom_range(0, 9) != 0)
        push(20'($urandom_range(20'h60000, 20'h9ffff)),
             20'($urandom_range(20'h40000, 20'hbffff)));
      else
        push(20'($urandom), 20'($urandom));
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.raw_temp = '0;
    in_if.raw_press = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = btc_pkg::CFG_TEMP;
    cfg_if.data = '0;
    temp_coeffs = '0;
    press_lo = '0;
    press_hi = '0;
    press_nine = '0;
    n_errors = 0;
    n_checked = 0;
    n_invalid = 0;
    n_sat = 0;
    calm = 1'b0;
    stim_done = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset coefficients give a zero divisor
    push('0, '0);
    push(20'hfffff, 20'hfffff);
    drain();

    load_nominal();
    push(20'h7e6e0, 20'h65a20);
    push('0, '0);
    push(20'hfffff, 20'hfffff);
    push('0, 20'hfffff);
    push(20'hfffff, '0);
    push(20'h55555, 20'haaaaa);
    push(20'haaaaa, 20'h55555);
    push(20'h80000, 20'h80000);
    drain();

    write_reg(btc_pkg::CFG_TEMP, 48'hffff_ffff_ffff);
    write_reg(btc_pkg::CFG_PRESS_LO, 64'hffff_ffff_ffff_ffff);
    write_reg(btc_pkg::CFG_PRESS_HI, 64'hffff_ffff_ffff_ffff);
    write_reg(btc_pkg::CFG_PRESS_NINE, 64'hffff);
    push('0, '0);
    push(20'hfffff, 20'hfffff);
    push(20'h7ffff, 20'h12345);
    drain();

    write_reg(btc_pkg::CFG_TEMP, {16'h8000, 16'h7fff, 16'h0000});
    write_reg(btc_pkg::CFG_PRESS_LO, {16'h7fff, 16'h8000, 16'h7fff, 16'h0001});
    write_reg(btc_pkg::CFG_PRESS_HI, {16'h8000, 16'h7fff, 16'h8000, 16'h7fff});
    write_reg(btc_pkg::CFG_PRESS_NINE, 64'h8000);
    push(20'hfffff, '0);
    push('0, 20'hfffff);
    push(20'h3c000, 20'h7ffff);
    drain();

    // P1 zero forces the divisor to zero
    load_nominal();
    write_reg(btc_pkg::CFG_PRESS_LO, {16'h0b27, 16'hd0d0, 16'hd5d4, 16'h0000});
    push(20'h7e6e0, 20'h65a20);
    push(20'hfffff, 20'h00001);
    drain();

    load_nominal();
    random_block(N_RANDOM / 2, 1'b1);
    drain();
    for (int k = 0; k < 6; k++) begin
      random_coeffs();
      random_block(100, 1'b0);
      drain();
    end
    load_nominal();
    random_block(400, 1'b1);
    while (pending_samples.size() > 200) @(posedge clk_i);
    calm = 1'b1;
    stim_done = 1'b1;
  end

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_if.valid && in_if.ready) pending_samples.pop_front();
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_if.valid <= 1'b0;
      end else if ((in_if.valid && !in_if.ready) ||
                   (pending_samples.size() > 0 && !(in_if.valid && in_if.ready &&
                    pending_samples.size() == 0))) begin
        if (!(in_if.valid && !in_if.ready) && !calm && $urandom_range(0, 15) == 0) begin
          send_gap <= $urandom_range(0, 7);
          in_if.valid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          in_if.valid <= 1'b1;
          in_if.raw_temp <= pending_samples[0].raw_temp;
          in_if.raw_press <= pending_samples[0].raw_press;
        end else begin
          in_if.valid <= 1'b0;
        end
      end else begin
        in_if.valid <= 1'b0;
      end
      if (in_if.valid && in_if.ready)
        expected_readings.push_back(compensate({in_if.raw_temp, in_if.raw_press}));
    end
  end

  // receiver
  always @(posedge clk_i or negedge rst_ni) begin
    reading_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      recv_stall <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_readings.size() == 0) begin
          report("unexpected transfer", 0, 0);
        end else begin
          want = expected_readings.pop_front();
          n_checked++;
          if (!want.press_valid) n_invalid++;
          if (want.press_q8 == btc_pkg::PRESS_MAX || want.temp_centi == 16'sh7fff ||
              want.temp_centi == -16'sh8000) n_sat++;
          if (out_if.temp_centi !== want.temp_centi)
            report("temp_centi", out_if.temp_centi, want.temp_centi);
          if (out_if.press_q8 !== want.press_q8)
            report("press_q8", out_if.press_q8, want.press_q8);
          if (out_if.press_valid !== want.press_valid)
            report("press_valid", out_if.press_valid, want.press_valid);
        end
      end
      if (recv_stall > 0) begin
        recv_stall <= recv_stall - 1;
        out_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        recv_stall <= $urandom_range(0, 7);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
      timed_out <= 1'b0;
    end else if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
                 (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      timed_out <= 1'b1;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (stim_done || timed_out);
    while (!timed_out && (pending_samples.size() != 0 || expected_readings.size() != 0))
      @(posedge clk_i);
    if (timed_out) begin
      $display("[barometer_trim_compensation_unit] ERROR");
    end else begin
      repeat (200) @(posedge clk_i);
      $display("checked %0d readings, %0d with zero divisor, %0d saturated",
               n_checked, n_invalid, n_sat);
      $display("nominal, extreme and random trim sets, with stalls on both channels");
      if (n_errors == 0 && expected_readings.size() == 0)
        $display("[barometer_trim_compensation_unit] OK");
      else
        $display("[barometer_trim_compensation_unit] ERROR");
    end
    $finish;
  end
endmodule
